// File: hdl/cmdf_pkg.sv
// Shared types and constants for the dual-mode command framer.
// No dependencies; imported by every module of the framer.
package cmdf_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int BANK_SIZE = 256;
	localparam int BANK_AW = $clog2(BANK_SIZE);
	localparam int RAM_AW = BANK_AW + 1;
	localparam int CNT_W = 9;

	localparam logic [CNT_W-1:0] DEPTH_LIMIT = CNT_W'(BUFFER_DEPTH);
	localparam logic [7:0] INITIAL_LENGTH = 8'd10;
	localparam logic [CNT_W-1:0] LENGTH_BYTE_POS = CNT_W'(4);

	localparam logic [7:0] MARKER_RESET = 8'd120;
	localparam logic [7:0] TERM_RESET = 8'd10;
	localparam logic [7:0] OFFSET_RESET = 8'd8;

	typedef enum logic [1:0] {
		REG_LENGTH_MARKER = 2'd0,
		REG_TERMINATOR = 2'd1,
		REG_LENGTH_OFFSET = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_RECEIVE = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef struct packed {
		logic wr_en;
		logic [RAM_AW-1:0] wr_addr;
		logic [7:0] wr_data;
		logic rd_en;
		logic [RAM_AW-1:0] rd_addr;
	} ram_req_t;

	typedef struct packed {
		logic rd_ok;
		logic done;
		logic ready;
		logic [CNT_W-1:0] length;
		logic mode;
		logic ovf;
	} result_t;

endpackage

// File: hdl/cmdf_bank_ram.sv
// Two-bank frame buffer: one write port, one read port, registered read data.
// Depends on cmdf_pkg for address width and request type.
module cmdf_bank_ram (
	input logic clk,
	input cmdf_pkg::ram_req_t req,
	output logic [7:0] rd_data
);
	import cmdf_pkg::*;

	logic [7:0] mem [2*BANK_SIZE];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// File: hdl/cmdf_ctrl.sv
// Framing control: configuration registers, byte count, mode, bank select
// and ready flag; issues buffer requests. Depends on cmdf_pkg.
module cmdf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic accept,
	input logic command,
	input logic [7:0] rx_byte,
	input logic [7:0] read_index,
	input logic release_req,
	output cmdf_pkg::ram_req_t ram_req,
	output cmdf_pkg::result_t result
);
	import cmdf_pkg::*;

	logic [7:0] marker_q, term_q, offset_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0] expected_q;
	logic lmode_q, bank_q, ready_q;
	logic [CNT_W-1:0] ready_len_q;

	logic [CNT_W-1:0] count_d, count_inc;
	logic [7:0] expected_d;
	logic lmode_d, bank_d, ready_d;
	logic [CNT_W-1:0] ready_len_d;
	logic is_first, is_marker, cur_mode, full, store, complete;

	always_comb begin
		is_first = (count_q == '0);
		is_marker = (rx_byte == marker_q);
		cur_mode = is_first ? is_marker : lmode_q;
		full = (count_q >= DEPTH_LIMIT);
		count_inc = CNT_W'(count_q + CNT_W'(1));

		count_d = count_q;
		expected_d = expected_q;
		lmode_d = lmode_q;
		bank_d = bank_q;
		ready_d = ready_q;
		ready_len_d = ready_len_q;
		store = 1'b0;
		complete = 1'b0;

		result = '0;
		result.mode = lmode_q;

		if (command == CMD_RECEIVE) begin
			result.mode = cur_mode;
			lmode_d = cur_mode;
			if (is_first && is_marker) begin
				expected_d = INITIAL_LENGTH;
			end
			if (cur_mode) begin
				if (full) begin
					result.ovf = 1'b1;
					count_d = '0;
					lmode_d = 1'b0;
				end else begin
					store = 1'b1;
					count_d = count_inc;
					if (count_inc == LENGTH_BYTE_POS) begin
						expected_d = 8'(rx_byte + offset_q);
					end
					if (count_inc == {1'b0, expected_d}) begin
						complete = 1'b1;
					end
				end
			end else if (rx_byte == term_q) begin
				complete = 1'b1;
			end else if (full) begin
				result.ovf = 1'b1;
				count_d = '0;
				lmode_d = 1'b0;
			end else begin
				store = 1'b1;
				count_d = count_inc;
			end
			if (complete) begin
				ready_len_d = count_d;
				bank_d = ~bank_q;
				ready_d = 1'b1;
				count_d = '0;
				lmode_d = 1'b0;
			end
			result.done = complete;
		end else begin
			result.rd_ok = ready_q && ({1'b0, read_index} < ready_len_q);
			if (release_req) begin
				ready_d = 1'b0;
			end
		end
		result.ready = ready_d;
		result.length = ready_len_d;

		ram_req.wr_en = accept && store;
		ram_req.wr_addr = {bank_q, count_q[BANK_AW-1:0]};
		ram_req.wr_data = rx_byte;
		ram_req.rd_en = accept && (command == CMD_READ);
		ram_req.rd_addr = {~bank_q, read_index[BANK_AW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
			term_q <= TERM_RESET;
			offset_q <= OFFSET_RESET;
			count_q <= '0;
			expected_q <= '0;
			lmode_q <= 1'b0;
			bank_q <= 1'b0;
			ready_q <= 1'b0;
			ready_len_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LENGTH_MARKER: marker_q <= cfg_data;
					REG_TERMINATOR: term_q <= cfg_data;
					REG_LENGTH_OFFSET: offset_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				count_q <= count_d;
				expected_q <= expected_d;
				lmode_q <= lmode_d;
				bank_q <= bank_d;
				ready_q <= ready_d;
				ready_len_q <= ready_len_d;
			end
		end
	end

endmodule

// File: hdl/dual_mode_command_framer.sv
// Dual-mode command framer top level: control, frame buffer and output stages.
// Each accepted request passes the first stage register and then the output
// register before its result is valid; a stalled output holds both stages.
// Throughput: one request per cycle while in_stall is low; the buffer RAM takes
// one write or one read per request; its registered read port sets the extra stage.
// Reset (arst_n low) clears counts, mode, bank select, ready flag and
// configuration registers to their defaults; buffer contents are not cleared.
module dual_mode_command_framer (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic command,
	input logic [7:0] rx_byte,
	input logic [7:0] read_index,
	input logic release_req,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] read_data,
	output logic frame_done,
	output logic frame_ready,
	output logic [8:0] frame_length,
	output logic frame_mode,
	output logic overflow
);
	import cmdf_pkg::*;

	ram_req_t ram_req;
	result_t result;
	result_t res_s1;
	logic valid_s1;
	logic [7:0] ram_rdata;
	logic accept, advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	cmdf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.command(command),
		.rx_byte(rx_byte),
		.read_index(read_index),
		.release_req(release_req),
		.ram_req(ram_req),
		.result(result)
	);

	cmdf_bank_ram u_ram (
		.clk(clk),
		.req(ram_req),
		.rd_data(ram_rdata)
	);

	// The RAM read register only loads on an accepted read, so it holds
	// while the first stage is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= result;
		end
		if (advance) begin
			read_data <= res_s1.rd_ok ? ram_rdata : 8'd0;
			frame_done <= res_s1.done;
			frame_ready <= res_s1.ready;
			frame_length <= res_s1.length;
			frame_mode <= res_s1.mode;
			overflow <= res_s1.ovf;
		end
	end

endmodule

// File: bench/framer_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the dual-mode command framer: mirrors register writes,
// predicts the result of every accepted request and compares results in order.
// Depends on cmdf_pkg for the register, command and length constants.
module framer_result_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input logic command,
	input logic [7:0] rx_byte,
	input logic [7:0] read_index,
	input logic release_req,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] read_data,
	input logic frame_done,
	input logic frame_ready,
	input logic [8:0] frame_length,
	input logic frame_mode,
	input logic overflow,
	output int mismatches,
	output int outstanding,
	output int results_seen,
	output int frames_closed,
	output int overruns
);
	import cmdf_pkg::*;

	typedef struct packed {
		logic [7:0] read_data;
		logic done;
		logic ready;
		logic [8:0] length;
		logic mode;
		logic ovf;
	} framer_result_t;

	logic [7:0] marker_reg, term_reg, offset_reg;
	logic [8:0] byte_cnt;
	logic [7:0] target_len;
	logic len_mode;
	logic [7:0] bank_mem [0:511];
	logic rx_bank;
	logic ready_flag;
	logic [8:0] ready_len;
	framer_result_t awaited_q[$];

	// Returns 0 when the byte would land past the buffer; the frame is dropped.
	function automatic logic append_byte(logic [7:0] data);
		if (byte_cnt >= DEPTH_LIMIT) begin
			byte_cnt = '0;
			len_mode = 1'b0;
			return 1'b0;
		end
		bank_mem[{rx_bank, byte_cnt[7:0]}] = data;
		byte_cnt = byte_cnt + 9'd1;
		return 1'b1;
	endfunction

	// The finished frame moves to the host side even if an older one is still held.
	function automatic void close_frame();
		ready_len = byte_cnt;
		rx_bank = ~rx_bank;
		ready_flag = 1'b1;
		byte_cnt = '0;
		len_mode = 1'b0;
	endfunction

	function automatic framer_result_t predict_request(logic cmd, logic [7:0] data,
			logic [7:0] idx, logic rel);
		framer_result_t r;
		r = '0;
		if (cmd == CMD_RECEIVE) begin
			if (byte_cnt == '0) begin
				len_mode = (data == marker_reg);
				if (len_mode)
					target_len = INITIAL_LENGTH;
			end
			r.mode = len_mode;
			if (len_mode) begin
				if (!append_byte(data)) begin
					r.ovf = 1'b1;
				end else begin
					if (byte_cnt == LENGTH_BYTE_POS)
						target_len = data + offset_reg;
					if (byte_cnt == {1'b0, target_len}) begin
						close_frame();
						r.done = 1'b1;
					end
				end
			end else if (data == term_reg) begin
				close_frame();
				r.done = 1'b1;
			end else if (!append_byte(data)) begin
				r.ovf = 1'b1;
			end
		end else begin
			r.mode = len_mode;
			if (ready_flag && {1'b0, idx} < ready_len)
				r.read_data = bank_mem[{~rx_bank, idx}];
			if (rel)
				ready_flag = 1'b0;
		end
		r.ready = ready_flag;
		r.length = ready_len;
		return r;
	endfunction

	task automatic flag_error(string why, framer_result_t want, framer_result_t seen);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected data=%02h done=%b ready=%b len=%0d mode=%b ovf=%b, %s",
				$time, why, want.read_data, want.done, want.ready, want.length,
				want.mode, want.ovf,
				$sformatf("got data=%02h done=%b ready=%b len=%0d mode=%b ovf=%b",
				seen.read_data, seen.done, seen.ready, seen.length, seen.mode, seen.ovf));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		framer_result_t seen;
		framer_result_t want;
		if (!arst_n) begin
			marker_reg = MARKER_RESET;
			term_reg = TERM_RESET;
			offset_reg = OFFSET_RESET;
			byte_cnt = '0;
			target_len = '0;
			len_mode = 1'b0;
			rx_bank = 1'b0;
			ready_flag = 1'b0;
			ready_len = '0;
			awaited_q.delete();
			mismatches = 0;
			results_seen = 0;
			frames_closed = 0;
			overruns = 0;
		end else begin
			// Results are handled first: a request accepted on this edge cannot
			// have produced the result that leaves on the same edge.
			if (out_valid && !out_stall) begin
				seen = {read_data, frame_done, frame_ready, frame_length, frame_mode, overflow};
				results_seen++;
				if (seen.done)
					frames_closed++;
				if (seen.ovf)
					overruns++;
				if (awaited_q.size() == 0) begin
					flag_error("result without a pending request", '0, seen);
				end else begin
					want = awaited_q.pop_front();
					if (seen !== want)
						flag_error("result mismatch", want, seen);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_LENGTH_MARKER: marker_reg = cfg_data;
					REG_TERMINATOR: term_reg = cfg_data;
					REG_LENGTH_OFFSET: offset_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				awaited_q.push_back(predict_request(command, rx_byte, read_index, release_req));
		end
		outstanding = awaited_q.size();
	end

endmodule

// File: bench/dual_mode_command_framer_test.sv
`timescale 1ns / 1ps
// Testbench top for the dual-mode command framer: clock, reset, register
// writes, request and stall generation, watchdog and final verdict.
// Depends on cmdf_pkg, dual_mode_command_framer and framer_result_checker.
module dual_mode_command_framer_test;
	import cmdf_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [7:0] rx_byte;
	logic [7:0] read_index;
	logic release_req;
	logic out_valid;
	logic out_stall;
	logic [7:0] read_data;
	logic frame_done;
	logic frame_ready;
	logic [8:0] frame_length;
	logic frame_mode;
	logic overflow;

	int mismatches, outstanding, results_seen, frames_closed, overruns;
	int requests_sent, settings_used, idle_cycles;
	logic brisk;
	logic [7:0] cur_marker, cur_term, cur_offset;

	dual_mode_command_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.rx_byte(rx_byte),
		.read_index(read_index),
		.release_req(release_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.frame_done(frame_done),
		.frame_ready(frame_ready),
		.frame_length(frame_length),
		.frame_mode(frame_mode),
		.overflow(overflow)
	);

	framer_result_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.rx_byte(rx_byte),
		.read_index(read_index),
		.release_req(release_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.frame_done(frame_done),
		.frame_ready(frame_ready),
		.frame_length(frame_length),
		.frame_mode(frame_mode),
		.overflow(overflow),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.results_seen(results_seen),
		.frames_closed(frames_closed),
		.overruns(overruns)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both sides share the brisk flag, so some stretches run with no idling at all.
	function automatic int draw_wait();
		return brisk ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic send_request(cmd_t cmd, logic [7:0] data, logic [7:0] idx, logic rel);
		int gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		rx_byte <= data;
		read_index <= idx;
		release_req <= rel;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// Fields that a request does not use still carry random values.
	task automatic send_byte(logic [7:0] data);
		send_request(CMD_RECEIVE, data, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_read(logic [7:0] idx, logic rel);
		send_request(CMD_READ, 8'($urandom), idx, rel);
	endtask

	task automatic random_read();
		logic [7:0] idx;
		idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
		send_read(idx, $urandom_range(0, 3) == 0);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t which, logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_phase(logic [7:0] marker, logic [7:0] term, logic [7:0] offset);
		write_reg(REG_LENGTH_MARKER, marker);
		write_reg(REG_TERMINATOR, term);
		write_reg(REG_LENGTH_OFFSET, offset);
		cur_marker = marker;
		cur_term = term;
		cur_offset = offset;
		settings_used++;
	endtask

	// Terminator frame of len stored bytes; host reads are mixed in now and then.
	task automatic term_frame(int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			do b = 8'($urandom); while (b == cur_term || (i == 0 && b == cur_marker));
			if ($urandom_range(0, 7) == 0)
				random_read();
			send_byte(b);
		end
		send_byte(cur_term);
	endtask

	// Length frame of total bytes; the fourth byte is chosen so that the frame
	// closes exactly after the last one.
	task automatic length_frame(int total);
		logic [7:0] b;
		send_byte(cur_marker);
		for (int i = 2; i <= total; i++) begin
			b = (i == 4) ? 8'(total) - cur_offset : 8'($urandom);
			if ($urandom_range(0, 7) == 0)
				random_read();
			send_byte(b);
		end
	endtask

	task automatic random_traffic(int quota);
		int base;
		int n;
		logic [7:0] b;
		base = requests_sent;
		while (requests_sent - base < quota) begin
			brisk = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: term_frame($urandom_range(0, 20));
				4, 5, 6: length_frame(($urandom_range(0, 19) == 0) ?
					$urandom_range(25, 120) : $urandom_range(4, 24));
				7: begin
					// Loose bytes that break into or merge with the next frame.
					n = $urandom_range(1, 6);
					repeat (n) begin
						b = 8'($urandom);
						if (b == cur_marker)
							b = b ^ 8'h01;
						send_byte(b);
					end
				end
				default: begin
					n = $urandom_range(1, 4);
					repeat (n) random_read();
				end
			endcase
		end
	endtask

	// Result-side stall: a random hold before each result, then wait for it.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = draw_wait();
			@(negedge clk);
			out_stall <= (hold != 0);
			if (hold > 1)
				repeat (hold - 1) @(negedge clk);
			if (hold != 0) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("Watchdog expired: no handshake for %0d cycles", IDLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LENGTH_MARKER;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		command = CMD_RECEIVE;
		rx_byte = 8'h00;
		read_index = 8'h00;
		release_req = 1'b0;
		out_stall = 1'b0;
		brisk = 1'b0;
		requests_sent = 0;
		settings_used = 1;
		idle_cycles = 0;
		cur_marker = MARKER_RESET;
		cur_term = TERM_RESET;
		cur_offset = OFFSET_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset register values.
		send_read(8'd0, 1'b0);
		send_byte(cur_term);
		send_read(8'd0, 1'b1);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h55);
		send_byte(cur_term);
		send_read(8'hFF, 1'b0);
		send_read(8'd2, 1'b0);
		send_read(8'd0, 1'b1);
		send_byte(cur_marker);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hAA);
		send_byte(cur_term);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_read(8'd7, 1'b1);
		send_read(8'd5, 1'b0);
		random_traffic(25);
		settle();

		// Capacity: a terminator frame that fills the buffer exactly, then a
		// length frame whose length lands below the count and overruns.
		set_phase(8'h00, 8'hFF, 8'h00);
		term_frame(256);
		send_read(8'hFF, 1'b0);
		send_read(8'h00, 1'b1);
		send_byte(cur_marker);
		for (int i = 2; i <= 257; i++)
			send_byte((i == 4) ? 8'($urandom_range(0, 3)) - cur_offset : 8'($urandom));
		random_traffic(10);
		settle();

		// Marker equal to the terminator: the marker wins on a first byte.
		set_phase(8'h5A, 8'h5A, 8'hFF);
		random_traffic(15);
		settle();
		set_phase(8'hFF, 8'h00, 8'h80);
		random_traffic(15);
		settle();
		set_phase(8'($urandom), 8'($urandom), 8'($urandom));
		random_traffic(15);
		settle();
		set_phase(8'($urandom), 8'($urandom), 8'($urandom));
		random_traffic(10);
		settle();
		repeat (8) @(posedge clk);

		$display("Covered %0d requests over %0d register settings: %0d results checked,",
			requests_sent, settings_used, results_seen);
		$display("%0d frames closed, %0d overruns, %0d mismatches, %0d results missing.",
			frames_closed, overruns, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
hdl/cmdf_pkg.sv
hdl/cmdf_bank_ram.sv
hdl/cmdf_ctrl.sv
hdl/dual_mode_command_framer.sv
bench/framer_result_checker.sv
bench/dual_mode_command_framer_test.sv
